// File: rtl/id_bitmap_allocator_defines.svh
// assertion macros shared by the allocator checker
`ifndef ID_BITMAP_ALLOCATOR_DEFINES_SVH
`define ID_BITMAP_ALLOCATOR_DEFINES_SVH

// condition must hold in the same cycle
`define IBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iba check failed");

// condition must hold in the following cycle
`define IBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iba check failed");

`endif

// File: rtl/iba_pkg.sv
// types and constants of the identifier bitmap allocator
`default_nettype none
package iba_pkg;

  localparam int NUM_IDS = 4096;
  localparam int WORD_W  = 64;
  localparam int ROWS    = NUM_IDS / WORD_W;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int IDX_W   = ROW_W + BIT_W;
  localparam int ID_W    = 16;
  localparam int COUNT_W = 13;

  localparam logic [ID_W-1:0] BASE_RESET = ID_W'(300);

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

  typedef struct packed {
    logic            opcode;
    logic [ID_W-1:0] release_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]    granted_id;
    logic [1:0]         status;
    logic [COUNT_W-1:0] in_use;
  } rsp_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_W-1:0]  rd_row;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_row;
    logic [WORD_W-1:0] wr_word;
  } mem_cmd_t;

endpackage
`default_nettype wire

// File: rtl/iba_bitmap_mem.sv
// occupancy bitmap memory with per-row valid bits cleared at reset
`default_nettype none
module iba_bitmap_mem (
  input  wire                          clk,
  input  wire                          rst,
  input  wire iba_pkg::mem_cmd_t       cmd,
  output logic [iba_pkg::WORD_W-1:0]   rd_word
);
  import iba_pkg::*;

  logic [WORD_W-1:0] mem [ROWS];
  logic [ROWS-1:0]   row_valid;
  logic [WORD_W-1:0] rd_q;
  logic              rd_valid_q;

  // row valid bits, a row never written reads as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        row_valid[cmd.wr_row] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid_q <= row_valid[cmd.rd_row];
      end
    end
  end

  // storage array, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_row] <= cmd.wr_word;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[cmd.rd_row];
    end
  end

  assign rd_word = rd_valid_q ? rd_q : '0;

endmodule
`default_nettype wire

// File: rtl/id_bitmap_allocator.sv
// identifier bitmap allocator top level
// Usage:
//   Requests enter on start/req and are taken when start is high and busy is
//   low. opcode selects allocate or release; release_id names the id to give
//   back. Each request gives exactly one item on rsp, marked by a one-cycle
//   done strobe; the receiver cannot stall, so results are never held.
//   base_id is written through cfg_we/cfg_data; the user must write it only
//   while no request is in flight: the block itself does not enforce this.
// A full pool or an out-of-range release is answered from idle. An allocate
// of the entry at the in-use count, or a release, does one registered read of
// its row in the bitmap memory; if that entry is taken, a second read fetches
// the row picked from the row-full flags, or the pool is reported full when no
// row is open.
// busy stays high until the result is registered; a new request may be
// accepted in the cycle that result is shown.
// Reset clears the in-use count, the row-full flags and the row valid bits,
// so every id is free at once; base_id returns to 300.
`default_nettype none
module id_bitmap_allocator (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire iba_pkg::req_t           req,
  input  wire                          cfg_we,
  input  wire  [iba_pkg::ID_W-1:0]     cfg_data,
  output logic                         done,
  output iba_pkg::rsp_t                rsp
);
  import iba_pkg::*;

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_CHK_HINT = 2'd1;
  localparam logic [1:0] S_CHK_SCAN = 2'd2;
  localparam logic [1:0] S_CHK_REL  = 2'd3;

  // lowest clear bit of a row word
  function automatic logic [BIT_W:0] first_free_bit(input logic [WORD_W-1:0] w);
    logic [BIT_W:0] res;
    res = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        res = {1'b1, BIT_W'(i)};
      end
    end
    return res;
  endfunction

  // lowest row that still has a free entry
  function automatic logic [ROW_W:0] first_open_row(input logic [ROWS-1:0] f);
    logic [ROW_W:0] res;
    res = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!f[i]) begin
        res = {1'b1, ROW_W'(i)};
      end
    end
    return res;
  endfunction

  logic [1:0]         state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [ROWS-1:0]    full_rows, full_rows_next;
  logic [ID_W-1:0]    base_id;
  logic [ROW_W-1:0]   cur_row, cur_row_next;
  logic [BIT_W-1:0]   cur_bit, cur_bit_next;
  logic               done_next;
  rsp_t               rsp_next;
  mem_cmd_t           cmd;
  logic [WORD_W-1:0]  rd_word;
  logic [WORD_W-1:0]  new_word;
  logic [ID_W-1:0]    rel_idx;
  logic [BIT_W:0]     free_bit;
  logic [ROW_W:0]     open_row;
  logic [IDX_W-1:0]   pick;

  iba_bitmap_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_word (rd_word)
  );

  assign busy     = (state != S_IDLE);
  assign rel_idx  = req.release_id - base_id;
  assign free_bit = first_free_bit(rd_word);
  assign open_row = first_open_row(full_rows);

  // request sequencing, read-modify-write of one bitmap row
  always_comb begin
    state_next     = state;
    count_next     = count;
    full_rows_next = full_rows;
    cur_row_next   = cur_row;
    cur_bit_next   = cur_bit;
    done_next      = 1'b0;
    rsp_next       = rsp;
    cmd            = '0;
    new_word       = rd_word;
    pick           = {cur_row, cur_bit};
    case (state)
      S_IDLE: begin
        if (start) begin
          rsp_next.granted_id = '0;
          rsp_next.in_use     = count;
          if (req.opcode == OP_ALLOC) begin
            if (count >= COUNT_W'(NUM_IDS)) begin
              done_next       = 1'b1;
              rsp_next.status = ST_FULL;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_row   = count[IDX_W-1:BIT_W];
              cur_row_next = count[IDX_W-1:BIT_W];
              cur_bit_next = count[BIT_W-1:0];
              state_next   = S_CHK_HINT;
            end
          end else begin
            if (rel_idx >= ID_W'(NUM_IDS)) begin
              done_next       = 1'b1;
              rsp_next.status = ST_RANGE;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_row   = rel_idx[IDX_W-1:BIT_W];
              cur_row_next = rel_idx[IDX_W-1:BIT_W];
              cur_bit_next = rel_idx[BIT_W-1:0];
              state_next   = S_CHK_REL;
            end
          end
        end
      end
      S_CHK_HINT: begin
        if (!rd_word[cur_bit]) begin
          new_word[cur_bit]         = 1'b1;
          cmd.wr_en                 = 1'b1;
          cmd.wr_row                = cur_row;
          cmd.wr_word               = new_word;
          full_rows_next[cur_row]   = &new_word;
          count_next                = count + COUNT_W'(1);
          done_next                 = 1'b1;
          rsp_next.status           = ST_OK;
          rsp_next.granted_id       = base_id + ID_W'(pick);
          rsp_next.in_use           = count + COUNT_W'(1);
          state_next                = S_IDLE;
        end else if (open_row[ROW_W]) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_row   = open_row[ROW_W-1:0];
          cur_row_next = open_row[ROW_W-1:0];
          state_next   = S_CHK_SCAN;
        end else begin
          done_next       = 1'b1;
          rsp_next.status = ST_FULL;
          state_next      = S_IDLE;
        end
      end
      S_CHK_SCAN: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (free_bit[BIT_W]) begin
          pick                              = {cur_row, free_bit[BIT_W-1:0]};
          new_word[free_bit[BIT_W-1:0]]     = 1'b1;
          cmd.wr_en                         = 1'b1;
          cmd.wr_row                        = cur_row;
          cmd.wr_word                       = new_word;
          full_rows_next[cur_row]           = &new_word;
          count_next                        = count + COUNT_W'(1);
          rsp_next.status                   = ST_OK;
          rsp_next.granted_id               = base_id + ID_W'(pick);
          rsp_next.in_use                   = count + COUNT_W'(1);
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      S_CHK_REL: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (rd_word[cur_bit]) begin
          new_word[cur_bit]       = 1'b0;
          cmd.wr_en               = 1'b1;
          cmd.wr_row              = cur_row;
          cmd.wr_word             = new_word;
          full_rows_next[cur_row] = 1'b0;
          count_next              = (count != '0) ? count - COUNT_W'(1) : count;
          rsp_next.status         = ST_OK;
          rsp_next.in_use         = count_next;
        end else begin
          rsp_next.status = ST_NOT_ALLOC;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      full_rows <= '0;
      done      <= 1'b0;
      base_id   <= BASE_RESET;
    end else begin
      state     <= state_next;
      count     <= count_next;
      full_rows <= full_rows_next;
      done      <= done_next;
      if (cfg_we) begin
        base_id <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_row <= cur_row_next;
    cur_bit <= cur_bit_next;
    rsp     <= rsp_next;
  end

endmodule
`default_nettype wire

// File: rtl/iba_checker.sv
// port-level checks of the allocator and their bind
`default_nettype none
`include "id_bitmap_allocator_defines.svh"
module iba_checker (
  input wire                clk,
  input wire                rst,
  input wire                start,
  input wire                busy,
  input wire                done,
  input wire iba_pkg::rsp_t rsp
);
  import iba_pkg::*;

  // an accepted item either answers next cycle or keeps the block busy
  `IBA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)

  // the block goes idle only by delivering its result
  `IBA_ASSERT_NOW(a_idle_with_result, $fell(busy), done)

  // a result always follows an accepted item or a busy cycle
  `IBA_ASSERT_NOW(a_result_has_cause, done, $past(start && !busy) || $past(busy))

  // no id is handed out on a failed or release request
  `IBA_ASSERT_NOW(a_zero_on_failure, done && rsp.status != ST_OK, rsp.granted_id == '0)

endmodule

bind id_bitmap_allocator iba_checker u_iba_checker (.*);
`default_nettype wire

// File: bench/id_bitmap_allocator_chk.sv
// checker for the id bitmap allocator: predicts each response and compares it
module id_bitmap_allocator_chk
  import iba_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  req_t            req,
  input  logic            cfg_we,
  input  logic [ID_W-1:0] cfg_data,
  input  logic            done,
  input  rsp_t            rsp,
  output int              fails,
  output int              pending,
  output int              checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted allocator state
  bit              taken [NUM_IDS];
  int unsigned     live;
  logic [ID_W-1:0] pool_base;
  rsp_t            rsp_due_q[$];

  initial begin
    fails   = 0;
    pending = 0;
    checked = 0;
  end

  // apply one request to the predicted pool and return its response
  function automatic rsp_t serve(req_t r);
    rsp_t            o;
    int              pick;
    logic [ID_W-1:0] slot;
    o    = '0;
    pick = -1;
    if (r.opcode == OP_ALLOC) begin
      // try the entry at the in-use count, else the lowest free one
      if (live < NUM_IDS) begin
        if (!taken[live]) begin
          pick = live;
        end else begin
          for (int i = 0; i < NUM_IDS && pick < 0; i++) begin
            if (!taken[i]) pick = i;
          end
        end
      end
      if (pick < 0) begin
        o.status = ST_FULL;
      end else begin
        taken[pick]  = 1'b1;
        live++;
        o.granted_id = pool_base + ID_W'(pick);
        o.status     = ST_OK;
      end
    end else begin
      // entry index wraps modulo the id width
      slot = r.release_id - pool_base;
      if (slot >= NUM_IDS) begin
        o.status = ST_RANGE;
      end else if (!taken[slot]) begin
        o.status = ST_NOT_ALLOC;
      end else begin
        taken[slot] = 1'b0;
        if (live > 0) live--;
        o.status = ST_OK;
      end
    end
    o.in_use = COUNT_W'(live);
    return o;
  endfunction

  // retire responses oldest first, then record new items
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      foreach (taken[i]) taken[i] = 1'b0;
      live      = 0;
      pool_base = BASE_RESET;
      rsp_due_q.delete();
    end else begin
      if (done) begin
        if (rsp_due_q.size() == 0) begin
          $error("response with no request outstanding: granted_id %0d status %0d in_use %0d",
                 rsp.granted_id, rsp.status, rsp.in_use);
          fails++;
        end else begin
          want = rsp_due_q.pop_front();
          checked++;
          if (rsp.granted_id !== want.granted_id) begin
            $error("granted_id mismatch: expected %0d, actual %0d",
                   want.granted_id, rsp.granted_id);
            fails++;
          end
          if (rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp.status);
            fails++;
          end
          if (rsp.in_use !== want.in_use) begin
            $error("in_use mismatch: expected %0d, actual %0d", want.in_use, rsp.in_use);
            fails++;
          end
        end
      end
      if (cfg_we) pool_base = cfg_data;
      if (start && !busy) rsp_due_q.push_back(serve(req));
    end
    pending = rsp_due_q.size();
  end

endmodule

// File: bench/id_bitmap_allocator_tb.sv
// testbench top for the id bitmap allocator: stimulus, watchdog and verdict
module id_bitmap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iba_pkg::*;

  localparam int STALL_LIMIT = 500;

  logic            clk      = 1'b0;
  logic            rst      = 1'b1;
  logic            start    = 1'b0;
  logic            cfg_we   = 1'b0;
  logic [ID_W-1:0] cfg_data = '0;
  req_t            req      = '0;
  logic            busy;
  logic            done;
  rsp_t            rsp;

  int fails;
  int pending;
  int checked;

  // stimulus bookkeeping
  logic [ID_W-1:0] cur_base  = BASE_RESET;
  int              held[$];
  logic            op_q[$];
  int              sent      = 0;
  int              full_seen = 0;
  int              nbases    = 0;
  int              stretch   = 0;
  int              max_gap   = 0;
  int              stall     = 0;

  always #4 clk = ~clk;

  id_bitmap_allocator DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .rsp      (rsp)
  );

  id_bitmap_allocator_chk u_chk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .rsp      (rsp),
    .fails    (fails),
    .pending  (pending),
    .checked  (checked)
  );

  // track granted entries so releases can target live ones
  always @(posedge clk) begin
    logic            op;
    logic [ID_W-1:0] slot;
    if (!rst && done && op_q.size() > 0) begin
      op = op_q.pop_front();
      if (op == OP_ALLOC && rsp.status == ST_OK) begin
        slot = rsp.granted_id - cur_base;
        held.push_back(int'(slot));
      end
      if (rsp.status == ST_FULL) full_seen++;
    end
  end

  // one item, with a random gap and random junk on req while idle
  task automatic send(input logic op, input logic [ID_W-1:0] id);
    int   gap;
    req_t r;
    if (stretch == 0) begin
      stretch = $urandom_range(10, 60);
      max_gap = ($urandom_range(0, 2) == 0) ? 0 : 3;
    end
    stretch--;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      r.opcode     = 1'($urandom);
      r.release_id = ID_W'($urandom);
      start <= 1'b0;
      req   <= r;
      repeat (gap) @(posedge clk);
    end
    r.opcode     = op;
    r.release_id = id;
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    op_q.push_back(op);
    sent++;
  endtask

  // stop requesting and wait for every response
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_base(input logic [ID_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_base = v;
    nbases++;
  endtask

  task automatic release_held();
    int k;
    int slot;
    if (held.size() == 0) begin
      send(OP_RELEASE, ID_W'(cur_base + $urandom_range(0, NUM_IDS - 1)));
    end else begin
      k    = $urandom_range(0, held.size() - 1);
      slot = held[k];
      held.delete(k);
      send(OP_RELEASE, ID_W'(cur_base + slot));
    end
  endtask

  // mostly well-formed traffic, some in-pool and wild releases
  task automatic random_item(input int alloc_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) begin
      send(OP_ALLOC, ID_W'($urandom));
    end else if (roll < 90) begin
      release_held();
    end else if (roll < 95) begin
      send(OP_RELEASE, ID_W'(cur_base + $urandom_range(0, NUM_IDS - 1)));
    end else begin
      send(OP_RELEASE, ID_W'($urandom));
    end
  endtask

  // watchdog on cycles with no item and no response
  initial begin
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) stall = 0;
      else stall++;
    end
    $display("id_bitmap_allocator verification failed");
    $finish;
  end

  initial begin
    logic [ID_W-1:0] bases [6];
    bases[0] = '0;
    bases[1] = ID_W'(61440);
    bases[2] = BASE_RESET;
    bases[3] = ID_W'($urandom_range(0, 61440));
    bases[4] = ID_W'(16'h8000);
    bases[5] = ID_W'($urandom_range(0, 61440));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pool: release of a free entry and out-of-range edges
    send(OP_RELEASE, BASE_RESET);
    send(OP_RELEASE, ID_W'(BASE_RESET - 1));
    send(OP_RELEASE, ID_W'(BASE_RESET + NUM_IDS));
    send(OP_RELEASE, 16'hFFFF);
    send(OP_RELEASE, 16'h0000);
    // allocate at the count, then force the lowest-free search
    send(OP_ALLOC, 16'hFFFF);
    send(OP_ALLOC, 16'h0000);
    send(OP_ALLOC, ID_W'($urandom));
    send(OP_RELEASE, BASE_RESET);
    send(OP_ALLOC, ID_W'($urandom));
    send(OP_RELEASE, ID_W'(BASE_RESET + 1));
    send(OP_RELEASE, ID_W'(BASE_RESET + 1));
    send(OP_ALLOC, ID_W'($urandom));
    send(OP_RELEASE, ID_W'(BASE_RESET + NUM_IDS - 1));
    // base near the top: granted ids wrap, bitmap is kept
    set_base(16'hFFFF);
    send(OP_ALLOC, ID_W'($urandom));
    send(OP_RELEASE, 16'h0001);
    send(OP_RELEASE, 16'hFFFE);
    send(OP_RELEASE, 16'hFFFF);
    send(OP_RELEASE, 16'h0000);
    send(OP_RELEASE, 16'h0002);
    drain();
    held.delete();

    // random traffic over several base settings
    foreach (bases[p]) begin
      set_base(bases[p]);
      repeat (200) random_item((p % 2 == 0) ? 60 : 45);
    end

    // pool at the top of the id range: give back every tracked entry
    set_base(ID_W'(61440));
    drain();
    while (held.size() > 0) release_held();
    drain();
    repeat (100) random_item(55);

    // let any stray response surface
    drain();
    repeat (4) @(posedge clk);

    $display("%0d requests sent, %0d responses checked, %0d base settings, %0d full",
             sent, checked, nbases, full_seen);
    $display("pool grown and given back under several bases, with wrap, range and double release");
    if (fails == 0 && pending == 0) begin
      $display("id_bitmap_allocator verification clean");
    end else begin
      $display("id_bitmap_allocator verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/iba_pkg.sv
rtl/iba_bitmap_mem.sv
rtl/id_bitmap_allocator.sv
rtl/iba_checker.sv
bench/id_bitmap_allocator_chk.sv
bench/id_bitmap_allocator_tb.sv
